### hw/rtl/pef_pkg.sv
// ----------------------------------------------------------------------------
// pef_pkg
// Shared types and constants for the presence edge event FIFO: request
// codes, the stored event layout and the controller/datapath signal groups.
// ----------------------------------------------------------------------------
package pef_pkg;

  // Request codes carried on the action port.
  typedef enum logic [2:0] {
    ACT_SAMPLE  = 3'd0,
    ACT_POP     = 3'd1,
    ACT_DLV_OK  = 3'd2,
    ACT_DLV_BAD = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  // Threshold value after reset, in cm.
  localparam logic [15:0] THRESHOLD_RESET = 16'd150;

  // Number of events the queue holds, and the index and level widths.
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  // Event descriptor fields kept in the store next to the time stamp.
  typedef struct packed {
    logic [15:0] distance;
    logic [31:0] seq_num;
    logic        dropped;
    logic        asserted;
  } info_t;

  // One store entry.
  typedef struct packed {
    logic [63:0] stamp;
    info_t       info;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic sample;
    logic pop;
    logic dlv_ok;
    logic dlv_bad;
    logic clear;
    logic respond;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
  } status_t;

endpackage

### hw/rtl/pef_ctrl.sv
// ----------------------------------------------------------------------------
// pef_ctrl
// Request sequencer: takes a request, issues one execute step to the
// datapath and then strobes the result for one cycle.
// ----------------------------------------------------------------------------
module pef_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  pef_pkg::status_t status,
  output pef_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  state_t state;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Decode the latched request into at most one datapath operation.
  always_comb begin
    cmd         = '0;
    cmd.capture = (state == ST_IDLE) && start;
    cmd.respond = (state == ST_RESP);
    if (state == ST_EXEC) begin
      case (status.action)
        pef_pkg::ACT_SAMPLE:  cmd.sample  = 1'b1;
        pef_pkg::ACT_POP:     cmd.pop     = 1'b1;
        pef_pkg::ACT_DLV_OK:  cmd.dlv_ok  = 1'b1;
        pef_pkg::ACT_DLV_BAD: cmd.dlv_bad = 1'b1;
        pef_pkg::ACT_CLEAR:   cmd.clear   = 1'b1;
        default:              cmd.clear   = 1'b0;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESP);

  // An accepted request always leads to a result, through the execute state and then the result state.
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("accepted request did not produce a result");

  // Only one datapath operation is issued per request.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.sample, cmd.pop, cmd.dlv_ok, cmd.dlv_bad, cmd.clear}) <= 1)
    else $error("more than one operation issued");

  // The result strobe never follows itself.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

endmodule

### hw/rtl/pef_dp.sv
// ----------------------------------------------------------------------------
// pef_dp
// Datapath: threshold register, presence flag, event store with its
// indices and level, the head-of-queue drop mark and the statistics.
// ----------------------------------------------------------------------------
module pef_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  pef_pkg::cmd_t             cmd,
  output pef_pkg::status_t          status,
  input  logic [2:0]                action,
  input  logic [15:0]               distance_cm,
  input  logic [63:0]               sample_time,
  input  logic                      cfg_write,
  input  logic [15:0]               cfg_data,
  output logic                      event_valid,
  output logic                      event_asserted,
  output logic                      event_dropped_before,
  output logic [31:0]               event_sequence,
  output logic [15:0]               event_distance,
  output logic [63:0]               event_time,
  output logic [pef_pkg::LVL_W-1:0] fifo_level,
  output logic                      presence_now,
  output logic [63:0]               total_count,
  output logic [63:0]               delivered_count,
  output logic [63:0]               dropped_count,
  output logic [63:0]               last_event_time
);

  localparam int DEPTH = pef_pkg::QUEUE_DEPTH;
  localparam int IDX_W = pef_pkg::IDX_W;
  localparam int LVL_W = pef_pkg::LVL_W;

  // Latched request.
  logic [2:0]  act_q;
  logic [15:0] dist_q;
  logic [63:0] time_q;

  // Control state.
  logic [15:0]      threshold;
  logic             presence;
  logic [31:0]      seq;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [LVL_W-1:0] fill;
  logic             loss_pending;
  logic             head_drop;
  logic [63:0]      gen_total;
  logic [63:0]      dlv_total;
  logic [63:0]      drop_total;
  logic [63:0]      last_time;
  logic             ev_valid;
  logic             ev_hdrop;

  // Event store and its registered read data.
  pef_pkg::entry_t mem [DEPTH];
  pef_pkg::entry_t rdata;

  logic             now_present;
  logic             edge_seen;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] wr_idx_inc;
  logic [IDX_W-1:0] rd_idx_inc;
  logic [31:0]      seq_next;
  pef_pkg::entry_t  wr_entry;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= action;
      dist_q <= distance_cm;
      time_q <= sample_time;
    end
  end

  assign status.action = pef_pkg::action_t'(act_q);

  // Sample compare, index wrap and the event to be written.
  always_comb begin
    now_present = (dist_q < threshold);
    edge_seen   = (now_present != presence);
    full        = (fill == LVL_W'(DEPTH));
    empty       = (fill == '0);
    wr_idx_inc  = (wr_idx == IDX_W'(DEPTH - 1)) ? '0 : wr_idx + 1'b1;
    rd_idx_inc  = (rd_idx == IDX_W'(DEPTH - 1)) ? '0 : rd_idx + 1'b1;
    seq_next    = seq + 32'd1;
    wr_entry.stamp         = time_q;
    wr_entry.info.distance = dist_q;
    wr_entry.info.seq_num  = seq_next;
    wr_entry.info.dropped  = loss_pending | full;
    wr_entry.info.asserted = now_present;
  end

  // Store write on an edge event, registered read at the head.
  always_ff @(posedge clk) begin
    if (cmd.sample && edge_seen) begin
      mem[wr_idx] <= wr_entry;
    end
    rdata <= mem[rd_idx];
  end

  // Queue state, presence and statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= pef_pkg::THRESHOLD_RESET;
      presence     <= 1'b0;
      seq          <= '0;
      wr_idx       <= '0;
      rd_idx       <= '0;
      fill         <= '0;
      loss_pending <= 1'b0;
      head_drop    <= 1'b0;
      gen_total    <= '0;
      dlv_total    <= '0;
      drop_total   <= '0;
      last_time    <= '0;
      ev_valid     <= 1'b0;
      ev_hdrop     <= 1'b0;
    end else begin
      if (cfg_write) begin
        threshold <= cfg_data;
      end
      // Every new request starts without a popped event.
      if (cmd.capture) begin
        ev_valid <= 1'b0;
      end
      // Sample: push an event on a presence change.
      if (cmd.sample && edge_seen) begin
        presence     <= now_present;
        seq          <= seq_next;
        gen_total    <= gen_total + 64'd1;
        last_time    <= time_q;
        loss_pending <= 1'b0;
        wr_idx       <= wr_idx_inc;
        if (full) begin
          // The oldest event is overwritten and its mark goes with it.
          rd_idx     <= rd_idx_inc;
          drop_total <= drop_total + 64'd1;
          head_drop  <= 1'b0;
        end else begin
          fill <= fill + 1'b1;
        end
      end
      // Pop: the head entry is read at this edge.
      if (cmd.pop && !empty) begin
        ev_valid  <= 1'b1;
        ev_hdrop  <= head_drop;
        head_drop <= 1'b0;
        rd_idx    <= rd_idx_inc;
        fill      <= fill - 1'b1;
      end
      if (cmd.dlv_ok) begin
        dlv_total <= dlv_total + 64'd1;
      end
      // Failed delivery marks the head event, or the next one to come.
      if (cmd.dlv_bad) begin
        drop_total <= drop_total + 64'd1;
        if (empty) begin
          loss_pending <= 1'b1;
        end else begin
          head_drop <= 1'b1;
        end
      end
      if (cmd.clear) begin
        gen_total  <= '0;
        dlv_total  <= '0;
        drop_total <= '0;
        last_time  <= '0;
      end
    end
  end

  // Result fields; event fields read as zero without a popped event.
  assign event_valid          = ev_valid;
  assign event_asserted       = ev_valid & rdata.info.asserted;
  assign event_dropped_before = ev_valid & (rdata.info.dropped | ev_hdrop);
  assign event_sequence       = ev_valid ? rdata.info.seq_num : '0;
  assign event_distance       = ev_valid ? rdata.info.distance : '0;
  assign event_time           = ev_valid ? rdata.stamp : '0;
  assign fifo_level           = fill;
  assign presence_now         = presence;
  assign total_count          = gen_total;
  assign delivered_count      = dlv_total;
  assign dropped_count        = drop_total;
  assign last_event_time      = last_time;

  // A head mark only exists while events are queued.
  a_hdrop_queued: assert property (@(posedge clk) disable iff (rst)
    head_drop |-> !empty)
    else $error("head drop mark set on an empty queue");

  // A pending loss is consumed by the first push, so the queue is empty.
  a_loss_empty: assert property (@(posedge clk) disable iff (rst)
    loss_pending |-> empty)
    else $error("pending loss with events queued");

  // A pop from an empty queue changes nothing and returns no event.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && empty |=> $stable(rd_idx) && $stable(fill) && !ev_valid)
    else $error("pop from empty queue changed state");

  // The level never passes the depth.
  a_level: assert property (@(posedge clk) disable iff (rst)
    cmd.sample && full |=> fill == LVL_W'(DEPTH))
    else $error("queue level out of range");

endmodule

### hw/rtl/presence_edge_event_fifo.sv
// ----------------------------------------------------------------------------
// presence_edge_event_fifo
// Presence detector with an edge event queue and delivery statistics.
//
//   Channel   Handshake              Payload
//   request   start / busy           action, distance_cm, sample_time
//   result    done (one cycle)       event_*, fifo_level, presence_now, counts
//   config    cfg_valid / cfg_ready  cfg_data (presence threshold)
//
// A request is taken when start is high and busy is low. The controller then
// passes through its execute and result states; done is high in the result
// state, which the registered read of the event store needs. rst is
// synchronous and needs no clearing pass: the store is only read at occupied
// entries. The receiver cannot stall; done lasts one cycle.
// ----------------------------------------------------------------------------
module presence_edge_event_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                action,
  input  logic [15:0]               distance_cm,
  input  logic [63:0]               sample_time,
  output logic                      done,
  output logic                      event_valid,
  output logic                      event_asserted,
  output logic                      event_dropped_before,
  output logic [31:0]               event_sequence,
  output logic [15:0]               event_distance,
  output logic [63:0]               event_time,
  output logic [pef_pkg::LVL_W-1:0] fifo_level,
  output logic                      presence_now,
  output logic [63:0]               total_count,
  output logic [63:0]               delivered_count,
  output logic [63:0]               dropped_count,
  output logic [63:0]               last_event_time,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [15:0]               cfg_data
);

  pef_pkg::cmd_t    cmd;
  pef_pkg::status_t status;

  // The threshold register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Request sequencer.
  pef_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Queue, presence and statistics datapath.
  pef_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .action               (action),
    .distance_cm          (distance_cm),
    .sample_time          (sample_time),
    .cfg_write            (cfg_valid & cfg_ready),
    .cfg_data             (cfg_data),
    .event_valid          (event_valid),
    .event_asserted       (event_asserted),
    .event_dropped_before (event_dropped_before),
    .event_sequence       (event_sequence),
    .event_distance       (event_distance),
    .event_time           (event_time),
    .fifo_level           (fifo_level),
    .presence_now         (presence_now),
    .total_count          (total_count),
    .delivered_count      (delivered_count),
    .dropped_count        (dropped_count),
    .last_event_time      (last_event_time)
  );

endmodule

### tb/presence_edge_event_fifo_checker.sv
// ----------------------------------------------------------------------------
// presence_edge_event_fifo_checker
// Watches the request, result and threshold channels of the presence edge
// event queue. It keeps its own copy of the presence state, the event queue
// and the statistics. From each accepted request it predicts one report,
// and it compares every result strobe with the oldest predicted report.
// ----------------------------------------------------------------------------
module presence_edge_event_fifo_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [2:0]                action,
  input  logic [15:0]               distance_cm,
  input  logic [63:0]               sample_time,
  input  logic                      done,
  input  logic                      event_valid,
  input  logic                      event_asserted,
  input  logic                      event_dropped_before,
  input  logic [31:0]               event_sequence,
  input  logic [15:0]               event_distance,
  input  logic [63:0]               event_time,
  input  logic [pef_pkg::LVL_W-1:0] fifo_level,
  input  logic                      presence_now,
  input  logic [63:0]               total_count,
  input  logic [63:0]               delivered_count,
  input  logic [63:0]               dropped_count,
  input  logic [63:0]               last_event_time,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [15:0]               cfg_data,
  output int                        failures,
  output int                        pending,
  output int                        events_popped,
  output int                        overwrites
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = pef_pkg::QUEUE_DEPTH;
  localparam int LVL_W      = pef_pkg::LVL_W;
  localparam int NUM_FIELDS = 12;

  // Descriptor kept beside the time stamp of each queued event.
  typedef struct packed {
    logic [15:0] dist_cm;
    logic [31:0] seq_num;
    logic        dropped;
    logic        asserted;
  } edge_info_t;

  // Everything the block reports for one request.
  typedef struct packed {
    logic             valid;
    logic             asserted;
    logic             dropped;
    logic [31:0]      seq_num;
    logic [15:0]      dist_cm;
    logic [63:0]      stamp;
    logic [LVL_W-1:0] level;
    logic             presence;
    logic [63:0]      generated;
    logic [63:0]      delivered;
    logic [63:0]      lost;
    logic [63:0]      last_stamp;
  } report_t;

  // Shadow copy of the block state.
  logic [15:0] threshold;
  edge_info_t  info_mem [DEPTH];
  logic [63:0] stamp_mem [DEPTH];
  int          wr_ptr;
  int          rd_ptr;
  int          held;
  logic        loss_pending;
  logic        presence;
  logic [31:0] seq_count;
  logic [15:0] last_dist;
  logic [63:0] last_sample_stamp;
  logic [63:0] generated_total;
  logic [63:0] delivered_total;
  logic [63:0] lost_total;
  logic [63:0] last_edge_stamp;

  report_t expected_reports [$];
  int      fail_count;
  int      report_index;
  int      popped_count;
  int      overwrite_count;

  task automatic reset_model();
    threshold         = pef_pkg::THRESHOLD_RESET;
    wr_ptr            = 0;
    rd_ptr            = 0;
    held              = 0;
    loss_pending      = 1'b0;
    presence          = 1'b0;
    seq_count         = '0;
    last_dist         = '0;
    last_sample_stamp = '0;
    generated_total   = '0;
    delivered_total   = '0;
    lost_total        = '0;
    last_edge_stamp   = '0;
  endtask

  // Applies one request to the shadow state and returns the report it causes.
  task automatic predict_report(input logic [2:0] act, input logic [15:0] range_cm,
                                input logic [63:0] stamp, output report_t rep);
    edge_info_t fresh;
    logic       now_present;
    rep = '0;
    case (act)
      pef_pkg::ACT_SAMPLE: begin
        now_present       = range_cm < threshold;
        last_dist         = range_cm;
        last_sample_stamp = stamp;
        if (now_present != presence) begin
          presence        = now_present;
          seq_count       = seq_count + 32'd1;
          generated_total = generated_total + 64'd1;
          last_edge_stamp = stamp;
          fresh = '{dist_cm: range_cm, seq_num: seq_count, dropped: loss_pending,
                    asserted: now_present};
          loss_pending = 1'b0;
          // A full queue loses its oldest event to make room.
          if (held >= DEPTH) begin
            rd_ptr        = (rd_ptr + 1) % DEPTH;
            held          = held - 1;
            lost_total    = lost_total + 64'd1;
            fresh.dropped = 1'b1;
            overwrite_count++;
          end
          info_mem[wr_ptr]  = fresh;
          stamp_mem[wr_ptr] = stamp;
          wr_ptr            = (wr_ptr + 1) % DEPTH;
          held              = held + 1;
        end
      end
      pef_pkg::ACT_POP: begin
        if (held > 0) begin
          rep.valid    = 1'b1;
          rep.asserted = info_mem[rd_ptr].asserted;
          rep.dropped  = info_mem[rd_ptr].dropped;
          rep.seq_num  = info_mem[rd_ptr].seq_num;
          rep.dist_cm  = info_mem[rd_ptr].dist_cm;
          rep.stamp    = stamp_mem[rd_ptr];
          rd_ptr       = (rd_ptr + 1) % DEPTH;
          held         = held - 1;
          popped_count++;
        end
      end
      pef_pkg::ACT_DLV_OK: delivered_total = delivered_total + 64'd1;
      pef_pkg::ACT_DLV_BAD: begin
        // A failed delivery marks the oldest queued event, or is remembered
        // for the next event when nothing is queued.
        lost_total = lost_total + 64'd1;
        if (held > 0) info_mem[rd_ptr].dropped = 1'b1;
        else loss_pending = 1'b1;
      end
      pef_pkg::ACT_CLEAR: begin
        generated_total = '0;
        delivered_total = '0;
        lost_total      = '0;
        last_edge_stamp = '0;
      end
      default: ;
    endcase
    rep.level      = LVL_W'(held);
    rep.presence   = presence;
    rep.generated  = generated_total;
    rep.delivered  = delivered_total;
    rep.lost       = lost_total;
    rep.last_stamp = last_edge_stamp;
  endtask

  function automatic void flatten(input report_t r, output logic [63:0] v [NUM_FIELDS]);
    v = '{64'(r.valid), 64'(r.asserted), 64'(r.dropped), 64'(r.seq_num), 64'(r.dist_cm),
          r.stamp, 64'(r.level), 64'(r.presence), r.generated, r.delivered, r.lost,
          r.last_stamp};
  endfunction

  function automatic string field_name(input int i);
    case (i)
      0:       return "event_valid";
      1:       return "event_asserted";
      2:       return "event_dropped_before";
      3:       return "event_sequence";
      4:       return "event_distance";
      5:       return "event_time";
      6:       return "fifo_level";
      7:       return "presence_now";
      8:       return "total_count";
      9:       return "delivered_count";
      10:      return "dropped_count";
      default: return "last_event_time";
    endcase
  endfunction

  // Prints one line per failure and counts every one.
  task automatic log_failure(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Results are compared before a request at the same edge is predicted;
  // the block's latency keeps the two from belonging together.
  always @(posedge clk) begin
    report_t     got;
    report_t     want;
    logic [63:0] got_v [NUM_FIELDS];
    logic [63:0] want_v [NUM_FIELDS];
    if (rst) begin
      reset_model();
      expected_reports.delete();
      fail_count      = 0;
      report_index    = 0;
      popped_count    = 0;
      overwrite_count = 0;
    end else begin
      if (done) begin
        got = '{valid: event_valid, asserted: event_asserted,
                dropped: event_dropped_before, seq_num: event_sequence,
                dist_cm: event_distance, stamp: event_time, level: fifo_level,
                presence: presence_now, generated: total_count,
                delivered: delivered_count, lost: dropped_count,
                last_stamp: last_event_time};
        if (expected_reports.size() == 0) begin
          log_failure("result strobe with no request outstanding");
        end else begin
          want = expected_reports.pop_front();
          flatten(got, got_v);
          flatten(want, want_v);
          for (int i = 0; i < NUM_FIELDS; i++) begin
            if (got_v[i] !== want_v[i]) begin
              log_failure($sformatf("report %0d %s: got 0x%0h, expected 0x%0h",
                                    report_index, field_name(i), got_v[i], want_v[i]));
            end
          end
          report_index++;
        end
      end
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (start && !busy) begin
        predict_report(action, distance_cm, sample_time, want);
        expected_reports.push_back(want);
      end
    end
    failures      <= fail_count;
    pending       <= expected_reports.size();
    events_popped <= popped_count;
    overwrites    <= overwrite_count;
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the presence edge event queue with a short directed request list
// and then phases of random requests under several presence thresholds:
// toggling floods that overrun the queue, drains, and mixed traffic with
// delivery reports, clears and unused action codes. A checker module beside
// the block predicts and compares every report; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_PHASES    = 8;
  localparam int LVL_W         = pef_pkg::LVL_W;

  // Action codes the block leaves undefined.
  localparam logic [2:0] ACT_UNUSED_5 = 3'd5;
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

  typedef enum {MIX_PHASE, FLOOD_PHASE, DRAIN_PHASE} phase_kind_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       action = pef_pkg::ACT_SAMPLE;
  logic [15:0]      distance_cm = '0;
  logic [63:0]      sample_time = '0;
  logic             done;
  logic             event_valid;
  logic             event_asserted;
  logic             event_dropped_before;
  logic [31:0]      event_sequence;
  logic [15:0]      event_distance;
  logic [63:0]      event_time;
  logic [LVL_W-1:0] fifo_level;
  logic             presence_now;
  logic [63:0]      total_count;
  logic [63:0]      delivered_count;
  logic [63:0]      dropped_count;
  logic [63:0]      last_event_time;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [15:0]      cfg_data = '0;
  int               failures;
  int               pending;
  int               events_popped;
  int               overwrites;

  logic [15:0] cur_threshold = pef_pkg::THRESHOLD_RESET;
  logic [63:0] stamp_clock = 64'h0000_00FF_FFFF_0000;
  int          gap_max = 0;
  int          requests_sent = 0;
  int          settings_used = 1;
  int          stall_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  presence_edge_event_fifo dut (.*);

  presence_edge_event_fifo_checker checker_i (.*);

  // Issues one request and holds it until accepted. With no gap drawn, start
  // stays high so the next request follows at once.
  task automatic send_request(input logic [2:0] act, input logic [15:0] range_cm,
                              input logic [63:0] stamp);
    int gap;
    start       <= 1'b1;
    action      <= act;
    distance_cm <= range_cm;
    sample_time <= stamp;
    do @(posedge clk); while (busy);
    requests_sent++;
    gap = $urandom_range(gap_max, 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
  endtask

  // The threshold only changes with no request in flight.
  task automatic write_threshold(input logic [15:0] value);
    start <= 1'b0;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    cur_threshold = value;
    settings_used++;
  endtask

  // Distance mostly on the requested side of the threshold, often right at the edge.
  function automatic logic [15:0] pick_distance(input bit below);
    int thr = cur_threshold;
    if ($urandom_range(7, 0) == 0) return 16'($urandom);
    if (below && thr > 0) begin
      if ($urandom_range(3, 0) == 0) return 16'(thr - 1);
      return 16'($urandom_range(thr - 1, 0));
    end
    if ($urandom_range(3, 0) == 0) return cur_threshold;
    return 16'($urandom_range(65535, thr));
  endfunction

  // Mostly rising time stamps, sometimes an arbitrary one.
  function automatic logic [63:0] pick_stamp();
    stamp_clock = stamp_clock + 64'($urandom_range(1_000_000, 1));
    if ($urandom_range(7, 0) == 0) return {$urandom, $urandom};
    return stamp_clock;
  endfunction

  function automatic logic [2:0] pick_action(input phase_kind_t kind);
    int roll = $urandom_range(99, 0);
    case (kind)
      FLOOD_PHASE: begin
        if (roll < 88) return pef_pkg::ACT_SAMPLE;
        if (roll < 92) return pef_pkg::ACT_POP;
        if (roll < 96) return pef_pkg::ACT_DLV_BAD;
        return pef_pkg::ACT_DLV_OK;
      end
      DRAIN_PHASE: begin
        if (roll < 20) return pef_pkg::ACT_SAMPLE;
        if (roll < 85) return pef_pkg::ACT_POP;
        if (roll < 95) return pef_pkg::ACT_DLV_BAD;
        return pef_pkg::ACT_DLV_OK;
      end
      default: begin
        if (roll < 50) return pef_pkg::ACT_SAMPLE;
        if (roll < 70) return pef_pkg::ACT_POP;
        if (roll < 80) return pef_pkg::ACT_DLV_OK;
        if (roll < 90) return pef_pkg::ACT_DLV_BAD;
        if (roll < 94) return pef_pkg::ACT_CLEAR;
        return 3'($urandom_range(ACT_UNUSED_7, ACT_UNUSED_5));
      end
    endcase
  endfunction

  // Cycles without any handshake; a hang ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Watchdog: no handshake for %0d cycles, %0d reports outstanding",
             STALL_LIMIT, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    phase_kind_t kind;
    int          count;
    logic [2:0]  act;
    logic [15:0] next_thr;
    bit          flood_side;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset threshold.
    gap_max = 4;
    send_request(pef_pkg::ACT_POP, 16'hFFFF, '1);                 // pop with the queue empty
    send_request(pef_pkg::ACT_DLV_BAD, 16'($urandom), {$urandom, $urandom}); // loss pending
    send_request(pef_pkg::ACT_SAMPLE, 16'd0, 64'd0);              // rising edge takes the flag
    send_request(pef_pkg::ACT_SAMPLE, 16'd149, '1);               // still present
    send_request(pef_pkg::ACT_SAMPLE, 16'd150, 64'h8000_0000_0000_0000); // at threshold: falls
    send_request(pef_pkg::ACT_SAMPLE, 16'hFFFF, 64'h0123_4567_89AB_CDEF);  // still absent
    send_request(pef_pkg::ACT_SAMPLE, 16'd149, '1);               // rises again
    send_request(pef_pkg::ACT_DLV_BAD, 16'd0, 64'd0);             // marks the oldest event
    send_request(pef_pkg::ACT_DLV_OK, 16'hFFFF, '1);
    send_request(pef_pkg::ACT_POP, 16'd0, 64'd0);
    send_request(pef_pkg::ACT_POP, 16'd0, 64'd0);
    send_request(pef_pkg::ACT_POP, 16'd0, 64'd0);
    send_request(pef_pkg::ACT_POP, 16'd0, 64'd0);                 // empty again
    send_request(ACT_UNUSED_5, 16'hFFFF, '1);
    send_request(ACT_UNUSED_6, 16'd0, 64'd0);
    send_request(ACT_UNUSED_7, 16'hA5A5, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(pef_pkg::ACT_CLEAR, 16'd0, 64'd0);
    send_request(pef_pkg::ACT_SAMPLE, 16'hFFFF, 64'd5);           // falls after a clear
    send_request(pef_pkg::ACT_DLV_OK, 16'd0, 64'd0);
    send_request(pef_pkg::ACT_POP, 16'd0, 64'd0);

    // Random phases, each under its own threshold.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       next_thr = 16'd1000;
        1:       next_thr = 16'hFFFF;
        2:       next_thr = 16'd0;
        3:       next_thr = 16'd1;
        5:       next_thr = pef_pkg::THRESHOLD_RESET;
        default: next_thr = 16'($urandom);
      endcase
      write_threshold(next_thr);
      kind = (p % 4 == 0) ? FLOOD_PHASE : (p % 4 == 1) ? DRAIN_PHASE : MIX_PHASE;
      count = (kind == FLOOD_PHASE) ? 90 : (kind == DRAIN_PHASE) ? 60 : 30;
      flood_side = 1'b1;
      for (int i = 0; i < count; i++) begin
        act = pick_action(kind);
        if (act == pef_pkg::ACT_SAMPLE) begin
          // Floods alternate sides so nearly every sample makes an edge.
          if (kind == FLOOD_PHASE) begin
            send_request(act, pick_distance(flood_side), pick_stamp());
            flood_side = !flood_side;
          end else begin
            send_request(act, pick_distance($urandom_range(1, 0)), pick_stamp());
          end
        end else begin
          send_request(act, 16'($urandom), {$urandom, $urandom});
        end
      end
    end

    start <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d requests under %0d threshold settings,", requests_sent,
             settings_used);
    $display("with %0d events popped and %0d events overwritten on a full queue.",
             events_popped, overwrites);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
